FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Needs nothing else. Each macro places one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge while reset is released.
`define SRPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Signal holds its value in the cycle after the condition is seen.
`define SRPG_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> $stable(sig)) \
		else $error("%m: value did not hold");

`endif

FILE: hdl/srpg_pkg.sv
// Package for the stepper ramp pulse generator: widths, register reset values,
// register indexes and the structs passed between modules. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 32;

	typedef logic [3:0]  phase_t;
	typedef logic [15:0] reload_t;

	localparam reload_t START_RELOAD_RST     = 16'd35536;
	localparam reload_t MAX_RELOAD_RST       = 16'd58036;
	localparam reload_t RAMP_STEP_RST        = 16'd100;
	localparam logic [7:0] RAMP_AFTER_RST    = 8'd10;
	localparam logic [15:0] STEPS_PER_RUN_RST = 16'd4000;

	localparam phase_t PHASE_RST = 4'b0001;
	localparam phase_t PHASE_A   = 4'b0001;
	localparam phase_t PHASE_D   = 4'b1000;

	typedef enum logic [2:0] {
		REG_START_RELOAD = 3'd0,
		REG_MAX_RELOAD   = 3'd1,
		REG_RAMP_STEP    = 3'd2,
		REG_RAMP_AFTER   = 3'd3,
		REG_STEPS_PER_RUN = 3'd4
	} reg_idx_t;

	typedef struct packed {
		reload_t     start_reload;
		reload_t     max_reload;
		reload_t     ramp_step;
		logic [7:0]  ramp_after_steps;
		logic [15:0] steps_per_run;
	} srpg_cfg_t;

	typedef struct packed {
		phase_t phase;
		logic   step_pulse;
		logic   direction;
		logic   running;
		logic   finished;
	} srpg_res_t;

endpackage

`default_nettype wire

FILE: hdl/srpg_if.sv
// Valid/ready channel interfaces for the timer tick items and the drive results.
// Depends on srpg_pkg for the phase type.
`timescale 1ns / 1ps
`default_nettype none

interface srpg_item_if;
	logic valid;
	logic ready;
	logic tick;
	logic start_req;

	modport source (output valid, output tick, output start_req, input ready);
	modport sink (input valid, input tick, input start_req, output ready);
endinterface

interface srpg_result_if import srpg_pkg::*;;
	logic   valid;
	logic   ready;
	phase_t phase;
	logic   step_pulse;
	logic   direction;
	logic   running;
	logic   finished;

	modport source (output valid, output phase, output step_pulse, output direction,
		output running, output finished, input ready);
	modport sink (input valid, input phase, input step_pulse, input direction,
		input running, input finished, output ready);
endinterface

`default_nettype wire

FILE: hdl/srpg_apb_regs.sv
// APB configuration registers of the stepper ramp pulse generator.
// Depends on srpg_pkg for the register indexes, reset values and config struct.
`timescale 1ns / 1ps
`default_nettype none

module srpg_apb_regs import srpg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output srpg_cfg_t                  cfg
);

	srpg_cfg_t  cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_reload     <= START_RELOAD_RST;
			cfg_q.max_reload       <= MAX_RELOAD_RST;
			cfg_q.ramp_step        <= RAMP_STEP_RST;
			cfg_q.ramp_after_steps <= RAMP_AFTER_RST;
			cfg_q.steps_per_run    <= STEPS_PER_RUN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_RELOAD:  cfg_q.start_reload     <= pwdata[15:0];
				REG_MAX_RELOAD:    cfg_q.max_reload       <= pwdata[15:0];
				REG_RAMP_STEP:     cfg_q.ramp_step        <= pwdata[15:0];
				REG_RAMP_AFTER:    cfg_q.ramp_after_steps <= pwdata[7:0];
				REG_STEPS_PER_RUN: cfg_q.steps_per_run    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_RELOAD:  prdata = {16'd0, cfg_q.start_reload};
			REG_MAX_RELOAD:    prdata = {16'd0, cfg_q.max_reload};
			REG_RAMP_STEP:     prdata = {16'd0, cfg_q.ramp_step};
			REG_RAMP_AFTER:    prdata = {24'd0, cfg_q.ramp_after_steps};
			REG_STEPS_PER_RUN: prdata = {16'd0, cfg_q.steps_per_run};
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/srpg_core.sv
// Motor state and its registered update: timer, ramp, coil phase and run control.
// Depends on srpg_pkg. The state advances only when the top level strobes en.
`timescale 1ns / 1ps
`default_nettype none

module srpg_core import srpg_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      tick,
	input  wire logic      start_req,
	input  wire srpg_cfg_t cfg,
	output srpg_res_t      res
);

	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	reload_t                reload_q, reload_d;
	phase_t                 phase_q, phase_d;
	logic                   dir_q, dir_d;
	logic [15:0]            left_q, left_d;
	logic [7:0]             taken_q, taken_d;
	logic                   run_q, run_d;

	logic [7:0]  taken_inc;
	logic [16:0] ramp_sum;
	reload_t     ramp_val;
	logic        ramp_ok;
	logic        pulse;
	logic        done;

	assign taken_inc = (taken_q != 8'hFF) ? taken_q + 8'd1 : taken_q;
	assign ramp_ok   = (taken_inc >= cfg.ramp_after_steps) && (reload_q < cfg.max_reload);
	assign ramp_sum  = {1'b0, reload_q} + {1'b0, cfg.ramp_step};
	assign ramp_val  = (ramp_sum > {1'b0, cfg.max_reload}) ? cfg.max_reload : ramp_sum[15:0];

	always_comb begin
		timer_d  = timer_q;
		reload_d = reload_q;
		phase_d  = phase_q;
		dir_d    = dir_q;
		left_d   = left_q;
		taken_d  = taken_q;
		run_d    = run_q;
		pulse    = 1'b0;
		done     = 1'b0;
		if (start_req) begin
			dir_d    = 1'b0;
			reload_d = cfg.start_reload;
			timer_d  = TIMER_WIDTH'(cfg.start_reload);
			left_d   = cfg.steps_per_run;
			taken_d  = '0;
			run_d    = 1'b1;
		end else if (tick && run_q) begin
			if (timer_q == '1) begin
				// Overflow: reload with the value in force before this step's ramp.
				timer_d = TIMER_WIDTH'(reload_q);
				pulse   = 1'b1;
				if (!dir_q) begin
					phase_d = (phase_q == PHASE_A) ? PHASE_D : (phase_q >> 1);
				end else begin
					phase_d = (phase_q == PHASE_D) ? PHASE_A : (phase_q << 1);
				end
				taken_d = taken_inc;
				if (ramp_ok) begin
					reload_d = ramp_val;
				end
				if (left_q <= 16'd1) begin
					if (dir_q) begin
						run_d = 1'b0;
						done  = 1'b1;
					end
					dir_d    = 1'b1;
					left_d   = cfg.steps_per_run;
					taken_d  = '0;
					reload_d = cfg.start_reload;
				end else begin
					left_d = left_q - 16'd1;
				end
			end else begin
				timer_d = timer_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= TIMER_WIDTH'(START_RELOAD_RST);
			reload_q <= START_RELOAD_RST;
			phase_q  <= PHASE_RST;
			dir_q    <= 1'b0;
			left_q   <= STEPS_PER_RUN_RST;
			taken_q  <= '0;
			run_q    <= 1'b1;
		end else if (en) begin
			timer_q  <= timer_d;
			reload_q <= reload_d;
			phase_q  <= phase_d;
			dir_q    <= dir_d;
			left_q   <= left_d;
			taken_q  <= taken_d;
			run_q    <= run_d;
		end
	end

	assign res.phase      = phase_d;
	assign res.step_pulse = pulse;
	assign res.direction  = dir_d;
	assign res.running    = run_d;
	assign res.finished   = done;

endmodule

`default_nettype wire

FILE: hdl/stepper_ramp_pulse_generator_unit.sv
// Top level of the stepper ramp pulse generator: input register, result register
// and handshakes. Depends on srpg_pkg, srpg_if, srpg_apb_regs and srpg_core.
//
//   channel   direction  protocol         contents
//   item      in         valid/ready      tick, start_req
//   result    out        valid/ready      phase, step_pulse, direction, running, finished
//   apb       in         APB write/read   five configuration registers
//
// One item is taken per cycle unless the result stalls; each result passes the input
// register, then the result register. The motor state updates once per item, in
// the cycle the item leaves the input register. Reset loads the register reset
// values and a running forward ramp. A stalled result holds the input register,
// which still takes one more transfer while the result waits.
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_pulse_generator_unit import srpg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	srpg_item_if.sink                  item,
	srpg_result_if.source              result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	srpg_cfg_t cfg;
	srpg_res_t core_res;
	srpg_res_t res_q;
	logic      res_valid_q;
	logic      valid_s1;
	logic      tick_s1;
	logic      start_s1;
	logic      advance;
	logic      in_ready;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign in_ready   = !valid_s1 || advance;
	assign item.ready = in_ready;

	srpg_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srpg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.tick      (tick_s1),
		.start_req (start_s1),
		.cfg       (cfg),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && item.valid) begin
			tick_s1  <= item.tick;
			start_s1 <= item.start_req;
		end
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.phase      = res_q.phase;
	assign result.step_pulse = res_q.step_pulse;
	assign result.direction  = res_q.direction;
	assign result.running    = res_q.running;
	assign result.finished   = res_q.finished;

endmodule

`default_nettype wire

FILE: hdl/srpg_checker.sv
// Port-level checks on the result channel of the stepper ramp pulse generator,
// bound to the top level. Depends on assert_macros.svh and srpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srpg_checker import srpg_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire phase_t out_phase,
	input wire logic   out_step_pulse,
	input wire logic   out_direction,
	input wire logic   out_running,
	input wire logic   out_finished
);

	// The run that finishes is always the reverse run, and it ends on a step.
	`SRPG_ASSERT_IMPL(a_finish_on_step, clk, arst_n, out_valid && out_finished, out_direction && out_step_pulse)
	// Finishing stops the motor in the same transfer.
	`SRPG_ASSERT_IMPL(a_finish_stops, clk, arst_n, out_valid && out_finished, !out_running)
	// Wave drive keeps exactly one coil energised.
	`SRPG_ASSERT_IMPL(a_phase_onehot, clk, arst_n, out_valid, $onehot(out_phase))
	// A result waiting for the sink is held unchanged.
	`SRPG_ASSERT_HOLD(a_hold_phase, clk, arst_n, out_valid && !out_ready, out_phase)

endmodule

bind stepper_ramp_pulse_generator_unit srpg_checker u_srpg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_phase      (result.phase),
	.out_step_pulse (result.step_pulse),
	.out_direction  (result.direction),
	.out_running    (result.running),
	.out_finished   (result.finished)
);

`default_nettype wire

FILE: verif/stepper_ramp_pulse_generator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stepper_ramp_pulse_generator_unit: drives ticks and
// start requests, programs the APB registers and checks every drive result.
// Depends on srpg_pkg, srpg_if and the RTL of the unit.

module stepper_ramp_pulse_generator_unit_tb;
	import srpg_pkg::*;

	localparam int MAX_CYCLES      = 200000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int REPORT_LIMIT    = 10;

	// Tracks the motor state in step with the accepted ticks and holds the
	// drive results still owed by the unit.
	class ramp_scoreboard;
		srpg_cfg_t              cfg;
		logic [TIMER_WIDTH-1:0] timer_q;
		reload_t                reload_q;
		phase_t                 coil_q;
		logic                   dir_q;
		logic                   running_q;
		logic [15:0]            left_q;
		logic [7:0]             taken_q;
		srpg_res_t              expected_drive[$];
		int                     mismatches;

		function new();
			cfg.start_reload     = START_RELOAD_RST;
			cfg.max_reload       = MAX_RELOAD_RST;
			cfg.ramp_step        = RAMP_STEP_RST;
			cfg.ramp_after_steps = RAMP_AFTER_RST;
			cfg.steps_per_run    = STEPS_PER_RUN_RST;
			coil_q = PHASE_RST;
			mismatches = 0;
			restart_run();
		endfunction

		function void restart_run();
			dir_q     = 1'b0;
			reload_q  = cfg.start_reload;
			timer_q   = TIMER_WIDTH'(cfg.start_reload);
			left_q    = cfg.steps_per_run;
			taken_q   = 8'd0;
			running_q = 1'b1;
		endfunction

		function void write_register(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_START_RELOAD: cfg.start_reload = value;
				REG_MAX_RELOAD: cfg.max_reload = value;
				REG_RAMP_STEP: cfg.ramp_step = value;
				REG_RAMP_AFTER: cfg.ramp_after_steps = value[7:0];
				REG_STEPS_PER_RUN: cfg.steps_per_run = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_drive.size();
		endfunction

		function void note_item(logic tick, logic start_req);
			srpg_res_t   drive;
			logic        pulse;
			logic        done;
			logic [16:0] sum;
			pulse = 1'b0;
			done  = 1'b0;
			if (start_req) begin
				restart_run();
			end else if (tick && running_q) begin
				if (timer_q == '1) begin
					// The timer reloads with the value in force before this step's ramp.
					timer_q = TIMER_WIDTH'(reload_q);
					pulse = 1'b1;
					if (!dir_q)
						coil_q = (coil_q == PHASE_A) ? PHASE_D : (coil_q >> 1);
					else
						coil_q = (coil_q == PHASE_D) ? PHASE_A : (coil_q << 1);
					if (taken_q != 8'hFF)
						taken_q++;
					if (taken_q >= cfg.ramp_after_steps && reload_q < cfg.max_reload) begin
						sum = {1'b0, reload_q} + {1'b0, cfg.ramp_step};
						reload_q = (sum > {1'b0, cfg.max_reload}) ? cfg.max_reload : sum[15:0];
					end
					if (left_q <= 16'd1) begin
						if (dir_q) begin
							running_q = 1'b0;
							done = 1'b1;
						end
						dir_q    = 1'b1;
						left_q   = cfg.steps_per_run;
						taken_q  = 8'd0;
						reload_q = cfg.start_reload;
					end else begin
						left_q--;
					end
				end else begin
					timer_q++;
				end
			end
			drive.phase      = coil_q;
			drive.step_pulse = pulse;
			drive.direction  = dir_q;
			drive.running    = running_q;
			drive.finished   = done;
			expected_drive.push_back(drive);
		endfunction

		function void check_drive(srpg_res_t got);
			srpg_res_t want;
			if (expected_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected drive: ph %h pu %b dir %b run %b fin %b",
						$realtime, got.phase, got.step_pulse, got.direction, got.running,
						got.finished);
				return;
			end
			want = expected_drive.pop_front();
			if (got.phase !== want.phase || got.step_pulse !== want.step_pulse ||
					got.direction !== want.direction || got.running !== want.running ||
					got.finished !== want.finished) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: drive mismatch: expected ph %h pu %b dir %b run %b fin %b",
						$realtime, want.phase, want.step_pulse, want.direction, want.running,
						want.finished);
					$display("    got ph %h pu %b dir %b run %b fin %b",
						got.phase, got.step_pulse, got.direction, got.running, got.finished);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int                    sender_idle_pct;
	int                    receiver_stall_pct;
	ramp_scoreboard        scoreboard = new();

	srpg_item_if   item_ch();
	srpg_result_if result_ch();

	stepper_ramp_pulse_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (MAX_CYCLES) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: values are sampled as they stood before the edge, and ready
	// is redrawn for the next cycle.
	initial begin
		srpg_res_t got;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.phase      = result_ch.phase;
				got.step_pulse = result_ch.step_pulse;
				got.direction  = result_ch.direction;
				got.running    = result_ch.running;
				got.finished   = result_ch.finished;
				scoreboard.check_drive(got);
			end
			result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic send_item(input logic tick, input logic start_req);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.tick      <= tick;
		item_ch.start_req <= start_req;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		scoreboard.note_item(tick, start_req);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
	endtask

	// Each write returns the bus to idle before the next setup phase.
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(int'(idx) * 4);
		pwdata  <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		scoreboard.write_register(idx, value);
		@(posedge clk);
	endtask

	// Reprogramming only happens with the pipeline empty and settled.
	task automatic configure(input logic [15:0] start_reload, input logic [15:0] max_reload,
			input logic [15:0] ramp_step, input logic [7:0] ramp_after,
			input logic [15:0] steps_per_run);
		drain();
		repeat (4) @(posedge clk);
		write_reg(REG_START_RELOAD, start_reload);
		write_reg(REG_MAX_RELOAD, max_reload);
		write_reg(REG_RAMP_STEP, ramp_step);
		write_reg(REG_RAMP_AFTER, {8'd0, ramp_after});
		write_reg(REG_STEPS_PER_RUN, steps_per_run);
	endtask

	// Mostly ticks, with the occasional idle slot and a rare restart.
	task automatic run_ticks(input int count, input int send_pct, input int recv_pct,
			input bit pause_midway);
		sender_idle_pct    = send_pct;
		receiver_stall_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain();
			send_item($urandom_range(99) < 90, $urandom_range(999) < 10);
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.tick      <= 1'b0;
		item_ch.start_req <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the timer is far from overflow, and a tick that comes
		// with a start request is ignored.
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);

		configure(16'h0000, MAX_RELOAD_RST, RAMP_STEP_RST, RAMP_AFTER_RST, STEPS_PER_RUN_RST);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b0);

		// A step on every tick with zero steps per run: each step ends a run, the
		// second one stops the motor, and ticks are then dropped until a restart.
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 16'd0);
		send_item(1'b0, 1'b1);
		repeat (4) send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b0);

		// The ramp sum passes 16 bits and must clamp to the maximum, then stay there.
		configure(16'hFFFE, 16'hFFFF, 16'hFFFF, 8'd1, 16'd3);
		send_item(1'b0, 1'b1);
		repeat (6) send_item(1'b1, 1'b0);

		configure(16'hFFF8, 16'hFFFE, 16'd1, 8'd3, 16'd6);
		send_item(1'b0, 1'b1);
		run_ticks(ITEMS_PER_PHASE, 0, 0, 1'b1);

		configure(16'hFFFE, 16'hFFFF, 16'hFFFF, 8'd255, 16'd300);
		send_item(1'b0, 1'b1);
		run_ticks(ITEMS_PER_PHASE, 88, 0, 1'b0);

		configure(16'hFFFA, 16'hFFFD, 16'd2, 8'd5, 16'd8);
		send_item(1'b0, 1'b1);
		run_ticks(ITEMS_PER_PHASE, 0, 88, 1'b0);

		// Start reload above the maximum, so the reload never moves.
		configure(16'hFFF0, 16'h0000, 16'h0000, 8'd0, 16'hFFFF);
		send_item(1'b0, 1'b1);
		run_ticks(ITEMS_PER_PHASE, 24, 24, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
